### hdl/scu_pkg.sv
package scu_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int VAL_W       = 32;
    localparam int FRAC_W      = 16;
    localparam int MAG_W       = VAL_W + FRAC_W;
    localparam int EPS_W       = 16;

    localparam logic [2:0] KIND_PUSH = 3'd0;
    localparam logic [2:0] KIND_POP  = 3'd1;
    localparam logic [2:0] KIND_ADD  = 3'd2;
    localparam logic [2:0] KIND_SUB  = 3'd3;
    localparam logic [2:0] KIND_MUL  = 3'd4;
    localparam logic [2:0] KIND_DIV  = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FEW  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_ZDIV = 2'd3;

    localparam logic [2:0] ERR_FEW  = 3'b001;
    localparam logic [2:0] ERR_FULL = 3'b010;
    localparam logic [2:0] ERR_ZDIV = 3'b100;

    typedef struct packed {
        logic [2:0]              kind;
        logic signed [VAL_W-1:0] push_value;
    } t_cmd;

    typedef struct packed {
        logic signed [VAL_W-1:0] result_value;
        logic [1:0]              status;
        logic [2:0]              error_bits;
    } t_res;

    function automatic logic [VAL_W-1:0] f_mag(input logic [VAL_W-1:0] v);
        f_mag = v[VAL_W-1] ? (VAL_W'(0) - v) : v;
    endfunction

    function automatic logic [VAL_W-1:0] f_sat_sum(input logic [VAL_W:0] s);
        if (s[VAL_W] != s[VAL_W-1]) begin
            f_sat_sum = s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end else begin
            f_sat_sum = s[VAL_W-1:0];
        end
    endfunction

    function automatic logic [VAL_W-1:0] f_signed_sat(input logic [MAG_W-1:0] mag,
                                                      input logic neg);
        logic [MAG_W-1:0] lim;
        lim = {{(FRAC_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
        if (neg) begin
            if (mag > lim) begin
                f_signed_sat = {1'b1, {(VAL_W-1){1'b0}}};
            end else begin
                f_signed_sat = VAL_W'(0) - mag[VAL_W-1:0];
            end
        end else begin
            if (mag > lim) begin
                f_signed_sat = {1'b0, {(VAL_W-1){1'b1}}};
            end else begin
                f_signed_sat = mag[VAL_W-1:0];
            end
        end
    endfunction

endpackage

### hdl/scu_alu.sv
module scu_alu
    import scu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_div,
    input  logic [VAL_W-1:0] i_mag_a,
    input  logic [VAL_W-1:0] i_mag_b,
    output logic             o_done,
    output logic [MAG_W-1:0] o_mag
);

    localparam int CYC_W = $clog2(MAG_W + 1);

    logic             r_busy;
    logic             r_done;
    logic             r_div;
    logic [CYC_W-1:0] r_cnt;
    logic [VAL_W:0]   r_acc;
    logic [MAG_W-1:0] r_shf;
    logic [VAL_W-1:0] r_opd;

    logic [VAL_W:0]   w_trial;
    logic [VAL_W:0]   w_op_a;
    logic [VAL_W:0]   w_op_b;
    logic [VAL_W+1:0] w_sum;

    // One adder serves both: add for shift-add multiply, subtract for restoring divide.
    assign w_trial = {r_acc[VAL_W-1:0], r_shf[MAG_W-1]};
    assign w_op_a  = r_div ? w_trial : {1'b0, r_acc[VAL_W-1:0]};
    assign w_op_b  = r_div ? ~{1'b0, r_opd} : (r_shf[0] ? {1'b0, r_opd} : '0);
    assign w_sum   = {1'b0, w_op_a} + {1'b0, w_op_b} + {{(VAL_W+1){1'b0}}, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CYC_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_div;
            r_acc <= '0;
            if (i_div) begin
                r_cnt <= CYC_W'(MAG_W);
                r_shf <= {i_mag_a, {FRAC_W{1'b0}}};
                r_opd <= i_mag_b;
            end else begin
                r_cnt <= CYC_W'(VAL_W);
                r_shf <= {{FRAC_W{1'b0}}, i_mag_b};
                r_opd <= i_mag_a;
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt - CYC_W'(1);
            if (r_div) begin
                if (w_sum[VAL_W+1]) begin
                    r_acc <= w_sum[VAL_W:0];
                end else begin
                    r_acc <= w_trial;
                end
                r_shf <= {r_shf[MAG_W-2:0], w_sum[VAL_W+1]};
            end else begin
                r_acc <= {1'b0, w_sum[VAL_W:1]};
                r_shf <= {r_shf[MAG_W-1:VAL_W], w_sum[0], r_shf[VAL_W-1:1]};
            end
        end
    end

    assign o_done = r_done;
    assign o_mag  = r_div ? r_shf : {r_acc[VAL_W-1:0], r_shf[VAL_W-1:FRAC_W]};

endmodule

### hdl/stack_calculator_unit.sv
// Channel   Direction  Transfer condition             Payload
// command   in         start && !busy                 i_cmd (t_cmd)
// result    out        o_res_valid, one cycle         o_res (t_res)
// config    in         i_cfg_valid && o_cfg_ready     i_cfg_data (epsilon)
//
// Push, an unknown command and any command that fails its operand check finish in
// S_EXEC; pop goes on through S_POPR, add or sub through S_RDA and S_RDB, and a
// divide refused for its divisor also ends in S_RDB.
// Multiply and divide go on from S_RDB to S_ALU and use the bit-serial shared
// adder, which handles one product or quotient bit per cycle.
// Reset is synchronous and active low; the stack memory is not cleared.
// Busy stays high until the result strobe is issued; the receiver cannot stall.
module stack_calculator_unit
    import scu_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_cmd             i_cmd,
    output logic             o_res_valid,
    output t_res             o_res,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [EPS_W-1:0] i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_POPR = 3'd2;
    localparam logic [2:0] S_RDA  = 3'd3;
    localparam logic [2:0] S_RDB  = 3'd4;
    localparam logic [2:0] S_ALU  = 3'd5;

    logic [VAL_W-1:0] r_mem [STACK_DEPTH];

    logic [2:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_fill, n_fill;
    logic [2:0]        r_err, n_err;
    logic [EPS_W-1:0]  r_eps;
    t_cmd              r_cmd;
    logic [VAL_W-1:0]  r_a, n_a;
    logic              r_neg, n_neg;
    logic [VAL_W-1:0]  r_rd;
    t_res              r_res, n_res;
    logic              r_res_valid, n_res_valid;

    logic              w_rd_en;
    logic [ADDR_W-1:0] w_rd_addr;
    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [VAL_W-1:0]  w_wr_data;
    logic [CNT_W-1:0]  w_fill_m1;
    logic [CNT_W-1:0]  w_fill_m2;
    logic [VAL_W-1:0]  w_mag_a;
    logic [VAL_W-1:0]  w_mag_b;
    logic [VAL_W-1:0]  w_addsub;
    logic              w_alu_start;
    logic              w_alu_done;
    logic [MAG_W-1:0]  w_alu_mag;
    logic [VAL_W-1:0]  w_alu_val;

    scu_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_alu_start),
        .i_div   (r_cmd.kind == KIND_DIV),
        .i_mag_a (w_mag_a),
        .i_mag_b (w_mag_b),
        .o_done  (w_alu_done),
        .o_mag   (w_alu_mag)
    );

    assign w_fill_m1 = r_fill - CNT_W'(1);
    assign w_fill_m2 = r_fill - CNT_W'(2);
    assign w_mag_a   = f_mag(r_a);
    assign w_mag_b   = f_mag(r_rd);
    assign w_alu_val = f_signed_sat(w_alu_mag, r_neg);
    assign w_addsub  = (r_cmd.kind == KIND_SUB)
                     ? f_sat_sum({r_a[VAL_W-1], r_a} - {r_rd[VAL_W-1], r_rd})
                     : f_sat_sum({r_a[VAL_W-1], r_a} + {r_rd[VAL_W-1], r_rd});

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_err       = r_err;
        n_a         = r_a;
        n_neg       = r_neg;
        n_res       = r_res;
        n_res_valid = 1'b0;
        w_rd_en     = 1'b0;
        w_rd_addr   = w_fill_m1[ADDR_W-1:0];
        w_wr_en     = 1'b0;
        w_wr_addr   = w_fill_m2[ADDR_W-1:0];
        w_wr_data   = w_addsub;
        w_alu_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res.result_value = '0;
                n_res.status       = ST_OK;
                case (r_cmd.kind)
                    KIND_PUSH: begin
                        n_state     = S_IDLE;
                        n_res_valid = 1'b1;
                        if (r_fill >= CNT_W'(STACK_DEPTH)) begin
                            n_err        = r_err | ERR_FULL;
                            n_res.status = ST_FULL;
                        end else begin
                            w_wr_en   = 1'b1;
                            w_wr_addr = r_fill[ADDR_W-1:0];
                            w_wr_data = r_cmd.push_value;
                            n_fill    = r_fill + CNT_W'(1);
                            n_err     = '0;
                        end
                    end
                    KIND_POP: begin
                        if (r_fill < CNT_W'(1)) begin
                            n_state      = S_IDLE;
                            n_res_valid  = 1'b1;
                            n_err        = r_err | ERR_FEW;
                            n_res.status = ST_FEW;
                        end else begin
                            w_rd_en = 1'b1;
                            n_state = S_POPR;
                        end
                    end
                    KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
                        if (r_fill < CNT_W'(2)) begin
                            n_state      = S_IDLE;
                            n_res_valid  = 1'b1;
                            n_err        = r_err | ERR_FEW;
                            n_res.status = ST_FEW;
                        end else begin
                            w_rd_en = 1'b1;
                            n_state = S_RDA;
                        end
                    end
                    default: begin
                        n_state     = S_IDLE;
                        n_res_valid = 1'b1;
                    end
                endcase
                n_res.error_bits = n_err;
            end
            S_POPR: begin
                n_state            = S_IDLE;
                n_res_valid        = 1'b1;
                n_fill             = w_fill_m1;
                n_err              = '0;
                n_res.result_value = r_rd;
                n_res.error_bits   = '0;
            end
            S_RDA: begin
                n_a       = r_rd;
                w_rd_en   = 1'b1;
                w_rd_addr = w_fill_m2[ADDR_W-1:0];
                n_state   = S_RDB;
            end
            S_RDB: begin
                n_neg = r_a[VAL_W-1] ^ r_rd[VAL_W-1];
                case (r_cmd.kind)
                    KIND_ADD, KIND_SUB: begin
                        n_state            = S_IDLE;
                        n_res_valid        = 1'b1;
                        w_wr_en            = 1'b1;
                        n_fill             = w_fill_m1;
                        n_err              = '0;
                        n_res.result_value = w_addsub;
                        n_res.error_bits   = '0;
                    end
                    KIND_DIV: begin
                        if (w_mag_b == '0 || w_mag_b < VAL_W'(r_eps)) begin
                            n_state            = S_IDLE;
                            n_res_valid        = 1'b1;
                            n_fill             = w_fill_m2;
                            n_err              = r_err | ERR_ZDIV;
                            n_res.result_value = '0;
                            n_res.status       = ST_ZDIV;
                            n_res.error_bits   = r_err | ERR_ZDIV;
                        end else begin
                            w_alu_start = 1'b1;
                            n_state     = S_ALU;
                        end
                    end
                    default: begin
                        w_alu_start = 1'b1;
                        n_state     = S_ALU;
                    end
                endcase
            end
            S_ALU: begin
                w_wr_data = w_alu_val;
                if (w_alu_done) begin
                    n_state            = S_IDLE;
                    n_res_valid        = 1'b1;
                    w_wr_en            = 1'b1;
                    n_fill             = w_fill_m1;
                    n_err              = '0;
                    n_res.result_value = w_alu_val;
                    n_res.error_bits   = '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_err       <= '0;
            r_eps       <= EPS_W'(1);
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_err       <= n_err;
            r_res_valid <= n_res_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_eps <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cmd <= i_cmd;
        end
        r_a   <= n_a;
        r_neg <= n_neg;
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd <= r_mem[w_rd_addr];
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(STACK_DEPTH))
        else $error("stack fill count beyond depth");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer did not raise busy");

    a_alu_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_alu_done |-> (r_state == S_ALU))
        else $error("arithmetic unit finished outside its wait state");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == ST_FULL) |-> o_res.error_bits[1])
        else $error("full status without its error bit");

endmodule

### bench/tb_stack_calculator_unit.sv
module tb_stack_calculator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import scu_pkg::*;

    localparam logic [2:0] KIND_RSVD6 = 3'd6;
    localparam logic [2:0] KIND_RSVD7 = 3'd7;
    localparam logic [2:0] ERR_NONE   = 3'b000;

    localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;

    localparam int DIR_N       = 22;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic [2:0]       kind;
        logic [VAL_W-1:0] value;
        logic             known;
        t_res             res;
    } t_row;

    logic             i_clk;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    logic             busy;
    t_cmd             i_cmd       = '0;
    logic             o_res_valid;
    t_res             o_res;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [EPS_W-1:0] i_cfg_data  = '0;

    logic [VAL_W-1:0] model_stack [STACK_DEPTH];
    int               model_fill = 0;
    logic [2:0]       model_err  = ERR_NONE;
    logic [EPS_W-1:0] model_eps  = 16'd1;

    t_res pending_results [$];
    t_row dir_tab [DIR_N];
    int   n_sent = 0;
    int   n_results = 0;
    int   n_fail = 0;
    int   n_cycles = 0;
    int   seen_status [4] = '{0, 0, 0, 0};

    stack_calculator_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [VAL_W-1:0] q_saturate(input longint v);
        if (v > Q_MAX) begin
            return VAL_MAX;
        end
        if (v < Q_MIN) begin
            return VAL_MIN;
        end
        return VAL_W'(v);
    endfunction

    function automatic t_res calc_outcome(input t_cmd c);
        t_res   r;
        longint a;
        longint b;
        longint ma;
        longint mb;
        logic   neg;
        r = '0;
        case (c.kind)
            KIND_PUSH: begin
                if (model_fill >= STACK_DEPTH) begin
                    r.status = ST_FULL;
                    model_err |= ERR_FULL;
                end else begin
                    model_stack[model_fill] = c.push_value;
                    model_fill++;
                    model_err = ERR_NONE;
                end
            end
            KIND_POP: begin
                if (model_fill < 1) begin
                    r.status = ST_FEW;
                    model_err |= ERR_FEW;
                end else begin
                    model_fill--;
                    r.result_value = model_stack[model_fill];
                    model_err = ERR_NONE;
                end
            end
            KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
                if (model_fill < 2) begin
                    r.status = ST_FEW;
                    model_err |= ERR_FEW;
                end else begin
                    a = longint'($signed(model_stack[model_fill-1]));
                    b = longint'($signed(model_stack[model_fill-2]));
                    model_fill -= 2;
                    ma = (a < 0) ? -a : a;
                    mb = (b < 0) ? -b : b;
                    neg = (a < 0) != (b < 0);
                    case (c.kind)
                        KIND_ADD: r.result_value = q_saturate(a + b);
                        KIND_SUB: r.result_value = q_saturate(a - b);
                        KIND_MUL: begin
                            r.result_value = q_saturate(neg ? -((ma * mb) >>> 16)
                                                            : (ma * mb) >>> 16);
                        end
                        default: begin
                            if (mb == 0 || mb < longint'(model_eps)) begin
                                r.status = ST_ZDIV;
                            end else begin
                                r.result_value = q_saturate(neg ? -((ma <<< 16) / mb)
                                                                : (ma <<< 16) / mb);
                            end
                        end
                    endcase
                    if (r.status == ST_OK) begin
                        model_stack[model_fill] = r.result_value;
                        model_fill++;
                        model_err = ERR_NONE;
                    end else begin
                        model_err |= ERR_ZDIV;
                    end
                end
            end
            default: ;
        endcase
        r.error_bits = model_err;
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] rand_q();
        case ($urandom_range(7))
            0: return VAL_MAX;
            1: return VAL_MIN;
            2: return '0;
            3: return VAL_W'((int'($urandom_range(40)) - 20) * 65536);
            4: return VAL_W'(int'($urandom_range(131072)) - 65536);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] divisor_pick();
        int m;
        m = $urandom_range(1, 196608);
        case ($urandom_range(3))
            0: m = 0;
            1: m = int'(model_eps) + int'($urandom_range(4)) - 2;
            2: return rand_q();
            default: ;
        endcase
        if (m < 0) begin
            m = 0;
        end
        return $urandom_range(1) ? VAL_W'(-m) : VAL_W'(m);
    endfunction

    task automatic send_cmd(input logic [2:0] kind, input logic [VAL_W-1:0] value,
                            input int idle_pct);
        t_cmd c;
        c.kind = kind;
        c.push_value = value;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(calc_outcome(c));
        n_sent++;
    endtask

    task automatic pause_until_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic set_epsilon(input logic [EPS_W-1:0] v);
        pause_until_drained();
        repeat (2) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        model_eps = v;
    endtask

    task automatic run_random(input int n, input int idle_pct);
        int         stop_at;
        int         sel;
        int         k;
        logic [2:0] op;
        stop_at = n_sent + n;
        while (n_sent < stop_at) begin
            sel = $urandom_range(99);
            op = 3'($urandom_range(KIND_ADD, KIND_DIV));
            if (sel < 3) begin
                pause_until_drained();
            end else if (sel < 7) begin
                // With 16 or fewer entries pop them all and one more, else pop 1 to 8; then send an arithmetic command.
                k = (model_fill > 16) ? $urandom_range(1, 8) : model_fill + 1;
                repeat (k) send_cmd(KIND_POP, $urandom, idle_pct);
                send_cmd(op, $urandom, idle_pct);
            end else if (sel < 10 && model_fill >= 40) begin
                while (model_fill < STACK_DEPTH) begin
                    send_cmd(KIND_PUSH, rand_q(), idle_pct);
                end
                send_cmd(KIND_PUSH, rand_q(), idle_pct);
            end else if (sel < 25) begin
                send_cmd(3'($urandom), $urandom, idle_pct);
            end else begin
                send_cmd(KIND_PUSH, (op == KIND_DIV) ? divisor_pick() : rand_q(), idle_pct);
                send_cmd(KIND_PUSH, rand_q(), idle_pct);
                send_cmd(op, $urandom, idle_pct);
                if ($urandom_range(2) == 0) begin
                    send_cmd(KIND_POP, $urandom, idle_pct);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_res_valid) begin
            n_results++;
            seen_status[o_res.status]++;
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing pending: %h", o_res);
                n_fail++;
            end else begin
                want = pending_results.pop_front();
                if (o_res.result_value !== want.result_value) begin
                    $error("result_value: expected %h, got %h",
                           want.result_value, o_res.result_value);
                    n_fail++;
                end
                if (o_res.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_res.status);
                    n_fail++;
                end
                if (o_res.error_bits !== want.error_bits) begin
                    $error("error_bits: expected %b, got %b",
                           want.error_bits, o_res.error_bits);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        logic [EPS_W-1:0] mid_eps;
        dir_tab = '{
            '{KIND_POP,   32'h0,          1'b1, {32'h0, ST_FEW, ERR_FEW}},
            '{KIND_DIV,   32'h0,          1'b1, {32'h0, ST_FEW, ERR_FEW}},
            '{KIND_RSVD6, 32'hFFFF_FFFF,  1'b1, {32'h0, ST_OK, ERR_FEW}},
            '{KIND_RSVD7, 32'h0,          1'b1, {32'h0, ST_OK, ERR_FEW}},
            '{KIND_PUSH,  VAL_MAX,        1'b1, {32'h0, ST_OK, ERR_NONE}},
            '{KIND_PUSH,  VAL_MAX,        1'b1, {32'h0, ST_OK, ERR_NONE}},
            '{KIND_ADD,   32'h0,          1'b1, {VAL_MAX, ST_OK, ERR_NONE}},
            '{KIND_PUSH,  VAL_MIN,        1'b1, {32'h0, ST_OK, ERR_NONE}},
            '{KIND_PUSH,  VAL_MIN,        1'b1, {32'h0, ST_OK, ERR_NONE}},
            '{KIND_ADD,   32'h0,          1'b1, {VAL_MIN, ST_OK, ERR_NONE}},
            '{KIND_MUL,   32'h0,          1'b1, {VAL_MIN, ST_OK, ERR_NONE}},
            '{KIND_POP,   32'h0,          1'b1, {VAL_MIN, ST_OK, ERR_NONE}},
            '{KIND_SUB,   32'h0,          1'b1, {32'h0, ST_FEW, ERR_FEW}},
            '{KIND_PUSH,  32'h0,          1'b1, {32'h0, ST_OK, ERR_NONE}},
            '{KIND_PUSH,  32'h0001_0000,  1'b1, {32'h0, ST_OK, ERR_NONE}},
            '{KIND_DIV,   32'h0,          1'b1, {32'h0, ST_ZDIV, ERR_ZDIV}},
            '{KIND_POP,   32'h0,          1'b1, {32'h0, ST_FEW, ERR_ZDIV | ERR_FEW}},
            '{KIND_PUSH,  32'h0000_0001,  1'b1, {32'h0, ST_OK, ERR_NONE}},
            '{KIND_PUSH,  32'h0001_0000,  1'b1, {32'h0, ST_OK, ERR_NONE}},
            '{KIND_DIV,   32'h0,          1'b1, {VAL_MAX, ST_OK, ERR_NONE}},
            '{KIND_PUSH,  32'hFFFF_8000,  1'b0, '0},
            '{KIND_MUL,   32'h0,          1'b0, '0}
        };
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_tab[i]) begin
            send_cmd(dir_tab[i].kind, dir_tab[i].value, 6);
            if (dir_tab[i].known) begin
                pending_results[pending_results.size()-1] = dir_tab[i].res;
            end
        end
        send_cmd(KIND_PUSH, 32'h0003_0000, 6);
        send_cmd(KIND_SUB, $urandom, 6);
        send_cmd(KIND_PUSH, 32'hFFFE_0000, 6);
        send_cmd(KIND_DIV, $urandom, 6);

        while (model_fill < STACK_DEPTH) begin
            send_cmd(KIND_PUSH, rand_q(), 6);
        end
        repeat (2) send_cmd(KIND_PUSH, rand_q(), 6);
        run_random(110, 6);

        set_epsilon(16'd0);
        run_random(150, 6);
        set_epsilon(16'hFFFF);
        run_random(150, 45);
        mid_eps = 16'($urandom_range(2, 65534));
        set_epsilon(mid_eps);
        run_random(150, 0);

        pause_until_drained();
        repeat (80) @(posedge i_clk);
        $display("Covered %0d commands and %0d results: %0d ok, %0d too few, %0d full, %0d div.",
                 n_sent, n_results, seen_status[ST_OK], seen_status[ST_FEW],
                 seen_status[ST_FULL], seen_status[ST_ZDIV]);
        $display("Divide threshold run at 1, 0, 65535 and %0d; sender gaps 6%%, 45%% and none.",
                 mid_eps);
        if (n_fail == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
